@@ hw/rtl/polar_goal_pose_controller_core_macros.svh @@
// Assertion macros used by the checker file.
`ifndef POLAR_GOAL_POSE_CONTROLLER_CORE_MACROS_SVH
`define POLAR_GOAL_POSE_CONTROLLER_CORE_MACROS_SVH

`define PGPC_ASSERT_IMPLY(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");

`define PGPC_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

@@ hw/rtl/pgpc_pkg.sv @@
`timescale 1ns / 1ps
package pgpc_pkg;

  localparam int unsigned CordicIterDefault = 16;
  localparam int unsigned CordicTableLen    = 24;
  localparam int unsigned PrescaleBits      = 10;
  localparam int unsigned CordicWidth       = 64;

  localparam logic signed [15:0] PiQ13    = 16'sd25736;
  localparam logic signed [17:0] TwoPiQ13 = 18'sd51472;
  localparam logic signed [35:0] PiQ30    = 36'sd3373259426;
  localparam logic [16:0]        InvGainQ16 = 17'd39797;

  localparam logic [2:0] RegGoalX     = 3'd0;
  localparam logic [2:0] RegGoalY     = 3'd1;
  localparam logic [2:0] RegGainDist  = 3'd2;
  localparam logic [2:0] RegGainHead  = 3'd3;
  localparam logic [2:0] RegGainFinal = 3'd4;
  localparam logic [2:0] RegStopRad   = 3'd5;

  typedef struct packed {
    logic signed [31:0] goal_x;
    logic signed [31:0] goal_y;
    logic signed [15:0] gain_distance;
    logic signed [15:0] gain_heading;
    logic signed [15:0] gain_final_angle;
    logic [30:0]        stop_radius;
  } cfg_t;

  typedef struct packed {
    logic                          zero;
    logic signed [CordicWidth-1:0] x;
    logic signed [CordicWidth-1:0] y;
    logic signed [35:0]            z;
  } cordic_t;

  function automatic logic signed [35:0] atan_q30(input logic [4:0] i);
    logic signed [35:0] r;
    begin
      case (i)
        5'd0: r = 36'sh03243F6A8;
        5'd1: r = 36'sh01DAC6705;
        5'd2: r = 36'sh00FADBAFC;
        5'd3: r = 36'sh007F56EA6;
        5'd4: r = 36'sh003FEAB76;
        5'd5: r = 36'sh001FFD55B;
        5'd6: r = 36'sh000FFFAAA;
        5'd7: r = 36'sh0007FFF55;
        5'd8: r = 36'sh0003FFFEA;
        5'd9: r = 36'sh0001FFFFD;
        5'd10: r = 36'sh0000FFFFF;
        5'd11: r = 36'sh00007FFFF;
        5'd12: r = 36'sh00003FFFF;
        5'd13: r = 36'sh00001FFFF;
        5'd14: r = 36'sh00000FFFF;
        5'd15: r = 36'sh000007FFF;
        5'd16: r = 36'sh000003FFF;
        5'd17: r = 36'sh000001FFF;
        5'd18: r = 36'sh000000FFF;
        5'd19: r = 36'sh0000007FF;
        5'd20: r = 36'sh0000003FF;
        5'd21: r = 36'sh0000001FF;
        5'd22: r = 36'sh0000000FF;
        5'd23: r = 36'sh00000007F;
        default: r = '0;
      endcase
      return r;
    end
  endfunction

  function automatic cordic_t cordic_prep(input logic signed [35:0] x_in,
                                          input logic signed [35:0] y_in);
    cordic_t c;
    logic signed [CordicWidth-1:0] xs;
    logic signed [CordicWidth-1:0] ys;
    begin
      xs = CordicWidth'(x_in) <<< PrescaleBits;
      ys = CordicWidth'(y_in) <<< PrescaleBits;
      c.zero = (x_in == '0) && (y_in == '0);
      c.z = '0;
      if (xs < 0) begin
        c.z = (ys >= 0) ? PiQ30 : -PiQ30;
        c.x = -xs;
        c.y = -ys;
      end else begin
        c.x = xs;
        c.y = ys;
      end
      return c;
    end
  endfunction

  function automatic logic signed [15:0] cordic_angle(input cordic_t c);
    logic signed [35:0] r;
    begin
      r = (c.z + 36'sd65536) >>> 17;
      if (c.zero) r = '0;
      else if (r > 36'(PiQ13)) r = 36'(PiQ13);
      else if (r < -36'(PiQ13)) r = -36'(PiQ13);
      return r[15:0];
    end
  endfunction

  function automatic logic signed [17:0] wrap_once(input logic signed [17:0] a);
    logic signed [17:0] r;
    begin
      r = a;
      if (r < -18'(PiQ13)) r = r + TwoPiQ13;
      if (r > 18'(PiQ13)) r = r - TwoPiQ13;
      return r;
    end
  endfunction

endpackage

@@ hw/rtl/pgpc_cordic_stage.sv @@
`timescale 1ns / 1ps
module pgpc_cordic_stage #(
  parameter int unsigned Shift = 0
) (
  input  logic              clk_i,
  input  logic              valid_i,
  input  pgpc_pkg::cordic_t a_i,
  input  pgpc_pkg::cordic_t b_i,
  output pgpc_pkg::cordic_t a_o,
  output pgpc_pkg::cordic_t b_o
);

  pgpc_pkg::cordic_t a_d, b_d, a_q, b_q;

  function automatic pgpc_pkg::cordic_t rot(input pgpc_pkg::cordic_t c);
    pgpc_pkg::cordic_t r;
    begin
      r = c;
      if (c.y >= 0) begin
        r.x = c.x + (c.y >>> Shift);
        r.y = c.y - (c.x >>> Shift);
        r.z = c.z + pgpc_pkg::atan_q30(5'(Shift));
      end else begin
        r.x = c.x - (c.y >>> Shift);
        r.y = c.y + (c.x >>> Shift);
        r.z = c.z - pgpc_pkg::atan_q30(5'(Shift));
      end
      return r;
    end
  endfunction

  assign a_d = rot(a_i);
  assign b_d = rot(b_i);

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      a_q <= a_d;
      b_q <= b_d;
    end
  end

  assign a_o = a_q;
  assign b_o = b_q;

endmodule

@@ hw/rtl/pgpc_front.sv @@
`timescale 1ns / 1ps
module pgpc_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  pgpc_pkg::cfg_t     cfg_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [15:0] quat_x_i,
  input  logic signed [15:0] quat_y_i,
  input  logic signed [15:0] quat_z_i,
  input  logic signed [15:0] quat_w_i,
  output logic               valid_o,
  output pgpc_pkg::cordic_t  yaw_o,
  output pgpc_pkg::cordic_t  goal_o
);

  logic               v1_q, v2_q;
  logic signed [31:0] xx_q, yy_q, zz_q, ww_q, xy_q, wz_q, xz_q, wy_q;
  logic signed [32:0] ex_q, ey_q;
  logic signed [35:0] cx_d, cy_d, norm_d, lock_d;
  logic               lock_big_d;
  pgpc_pkg::cordic_t  yaw_d, goal_d, yaw_q, goal_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      xx_q <= quat_x_i * quat_x_i;
      yy_q <= quat_y_i * quat_y_i;
      zz_q <= quat_z_i * quat_z_i;
      ww_q <= quat_w_i * quat_w_i;
      xy_q <= quat_x_i * quat_y_i;
      wz_q <= quat_w_i * quat_z_i;
      xz_q <= quat_x_i * quat_z_i;
      wy_q <= quat_w_i * quat_y_i;
      ex_q <= 33'(cfg_i.goal_x) - 33'(pos_x_i);
      ey_q <= 33'(cfg_i.goal_y) - 33'(pos_y_i);
    end
  end

  always_comb begin
    norm_d = 36'(ww_q) + 36'(xx_q) + 36'(yy_q) + 36'(zz_q);
    lock_d = (36'(xz_q) - 36'(wy_q)) <<< 1;
    if (lock_d < 0) lock_d = -lock_d;
    lock_big_d = !(lock_d < norm_d);
    cx_d = 36'(ww_q) + 36'(xx_q) - 36'(yy_q) - 36'(zz_q);
    cy_d = (36'(xy_q) + 36'(wz_q)) <<< 1;
    yaw_d = pgpc_pkg::cordic_prep(cx_d, cy_d);
    if (lock_big_d) yaw_d.zero = 1'b1;
    goal_d = pgpc_pkg::cordic_prep(36'(ex_q), 36'(ey_q));
  end

  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      yaw_q  <= yaw_d;
      goal_q <= goal_d;
    end
  end

  assign valid_o = v2_q;
  assign yaw_o   = yaw_q;
  assign goal_o  = goal_q;

endmodule

@@ hw/rtl/pgpc_back.sv @@
`timescale 1ns / 1ps
module pgpc_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  pgpc_pkg::cfg_t     cfg_i,
  input  pgpc_pkg::cordic_t  yaw_i,
  input  pgpc_pkg::cordic_t  goal_i,
  output logic               valid_o,
  output logic [30:0]        linear_velocity_o,
  output logic signed [31:0] angular_velocity_o,
  output logic [30:0]        distance_o,
  output logic signed [15:0] heading_error_o,
  output logic signed [15:0] final_angle_error_o,
  output logic               stopped_o
);

  logic [3:0]          v_q;
  logic signed [15:0]  yaw_d, bear_d;
  logic signed [80:0]  magp_q;
  logic                zero_q;
  logic signed [15:0]  yaw_q, bear_q;
  logic signed [81:0]  mag_r;
  logic [30:0]         rho_d, rho_q;
  logic signed [17:0]  alpha_d, beta_d;
  logic signed [15:0]  alpha_q, beta_q;
  logic signed [47:0]  lin_q;
  logic signed [33:0]  pa_q, pb_q;
  logic                stop_q;
  logic signed [47:0]  lin_r;
  logic signed [34:0]  ang_r;
  logic [30:0]         lin_d;
  logic signed [31:0]  ang_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= '0;
    else v_q <= {v_q[2:0], valid_i};
  end

  assign yaw_d  = pgpc_pkg::cordic_angle(yaw_i);
  assign bear_d = pgpc_pkg::cordic_angle(goal_i);

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      magp_q <= 81'(goal_i.x) * $signed({1'b0, pgpc_pkg::InvGainQ16});
      zero_q <= goal_i.zero;
      yaw_q  <= yaw_d;
      bear_q <= bear_d;
    end
  end

  always_comb begin
    mag_r = (82'(magp_q) + 82'(1 << 25)) >>> 26;
    if (zero_q || mag_r < 0) rho_d = '0;
    else if (mag_r > 82'sd2147483647) rho_d = 31'h7FFFFFFF;
    else rho_d = mag_r[30:0];
    alpha_d = pgpc_pkg::wrap_once(18'(bear_q) - 18'(yaw_q));
    beta_d  = pgpc_pkg::wrap_once(-alpha_d - 18'(yaw_q));
  end

  always_ff @(posedge clk_i) begin
    if (v_q[0]) begin
      rho_q   <= rho_d;
      alpha_q <= alpha_d[15:0];
      beta_q  <= beta_d[15:0];
      stop_q  <= rho_d < cfg_i.stop_radius;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v_q[1]) begin
      lin_q <= 48'(cfg_i.gain_distance) * 48'($signed({1'b0, rho_q}));
      pa_q  <= 34'(cfg_i.gain_heading) * 34'(alpha_q);
      pb_q  <= 34'(cfg_i.gain_final_angle) * 34'(beta_q);
    end
  end

  logic [30:0]        rho2_q;
  logic signed [15:0] alpha2_q, beta2_q;
  logic               stop2_q;

  always_ff @(posedge clk_i) begin
    if (v_q[1]) begin
      rho2_q   <= rho_q;
      alpha2_q <= alpha_q;
      beta2_q  <= beta_q;
      stop2_q  <= stop_q;
    end
  end

  always_comb begin
    lin_r = (lin_q + 48'sd2048) >>> 12;
    ang_r = (35'(pa_q) + 35'(pb_q) + 35'sd256) >>> 9;
    if (stop2_q || lin_r < 0) lin_d = '0;
    else if (lin_r > 48'sd2147483647) lin_d = 31'h7FFFFFFF;
    else lin_d = lin_r[30:0];
    if (stop2_q) ang_d = '0;
    else if (ang_r > 35'sd2147483647) ang_d = 32'sh7FFFFFFF;
    else if (ang_r < -35'sd2147483648) ang_d = 32'sh80000000;
    else ang_d = ang_r[31:0];
  end

  always_ff @(posedge clk_i) begin
    if (v_q[2]) begin
      linear_velocity_o   <= lin_d;
      angular_velocity_o  <= ang_d;
      distance_o          <= rho2_q;
      heading_error_o     <= alpha2_q;
      final_angle_error_o <= beta2_q;
      stopped_o           <= stop2_q;
    end
  end

  assign valid_o = v_q[3];

endmodule

@@ hw/rtl/polar_goal_pose_controller_core.sv @@
`timescale 1ns / 1ps
// Channel  | Ports                                   | Handshake
// config   | cfg_we_i, cfg_index_i, cfg_data_i       | written when cfg_we_i is high
// pose in  | pos_*_i, quat_*_i                       | taken when start_i high, busy_o low
// result   | linear_velocity_o ... stopped_o         | valid for one cycle with done_o
// An item passes from start through the front stages, the pipelined rotation
// stages and the back stages to done; a new item may enter in every cycle.
// Reset returns the config registers to their defaults and empties the pipeline.
// busy_o is always low and the result side is never stalled.
module polar_goal_pose_controller_core #(
  parameter int unsigned CordicIterations = pgpc_pkg::CordicIterDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               start_i,
  output logic               busy_o,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [15:0] quat_x_i,
  input  logic signed [15:0] quat_y_i,
  input  logic signed [15:0] quat_z_i,
  input  logic signed [15:0] quat_w_i,
  output logic               done_o,
  output logic [30:0]        linear_velocity_o,
  output logic signed [31:0] angular_velocity_o,
  output logic [30:0]        distance_o,
  output logic signed [15:0] heading_error_o,
  output logic signed [15:0] final_angle_error_o,
  output logic               stopped_o
);

  localparam int unsigned NumIter = (CordicIterations > pgpc_pkg::CordicTableLen) ?
                                    pgpc_pkg::CordicTableLen : CordicIterations;

  pgpc_pkg::cfg_t    cfg_q;
  logic              front_valid;
  pgpc_pkg::cordic_t yaw_c [NumIter+1];
  pgpc_pkg::cordic_t goal_c [NumIter+1];
  logic [NumIter:0]  v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.goal_x           <= '0;
      cfg_q.goal_y           <= '0;
      cfg_q.gain_distance    <= 16'sd410;
      cfg_q.gain_heading     <= 16'sd8192;
      cfg_q.gain_final_angle <= -16'sd41;
      cfg_q.stop_radius      <= 31'd13107;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        pgpc_pkg::RegGoalX:     cfg_q.goal_x           <= cfg_data_i;
        pgpc_pkg::RegGoalY:     cfg_q.goal_y           <= cfg_data_i;
        pgpc_pkg::RegGainDist:  cfg_q.gain_distance    <= cfg_data_i[15:0];
        pgpc_pkg::RegGainHead:  cfg_q.gain_heading     <= cfg_data_i[15:0];
        pgpc_pkg::RegGainFinal: cfg_q.gain_final_angle <= cfg_data_i[15:0];
        pgpc_pkg::RegStopRad:   cfg_q.stop_radius      <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  assign busy_o = 1'b0;

  pgpc_front u_front (
    .clk_i, .rst_ni,
    .valid_i (start_i),
    .cfg_i   (cfg_q),
    .pos_x_i, .pos_y_i, .quat_x_i, .quat_y_i, .quat_z_i, .quat_w_i,
    .valid_o (front_valid),
    .yaw_o   (yaw_c[0]),
    .goal_o  (goal_c[0])
  );

  assign v_q[0] = front_valid;

  for (genvar g = 0; g < NumIter; g++) begin : g_iter
    logic v_stage_q;
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) v_stage_q <= 1'b0;
      else v_stage_q <= v_q[g];
    end
    assign v_q[g+1] = v_stage_q;
    pgpc_cordic_stage #(.Shift(g)) u_stage (
      .clk_i,
      .valid_i (v_q[g]),
      .a_i     (yaw_c[g]),
      .b_i     (goal_c[g]),
      .a_o     (yaw_c[g+1]),
      .b_o     (goal_c[g+1])
    );
  end

  pgpc_back u_back (
    .clk_i, .rst_ni,
    .valid_i (v_q[NumIter]),
    .cfg_i   (cfg_q),
    .yaw_i   (yaw_c[NumIter]),
    .goal_i  (goal_c[NumIter]),
    .valid_o (done_o),
    .linear_velocity_o, .angular_velocity_o, .distance_o,
    .heading_error_o, .final_angle_error_o, .stopped_o
  );

endmodule

@@ hw/rtl/pgpc_checker.sv @@
`timescale 1ns / 1ps
`include "polar_goal_pose_controller_core_macros.svh"
module pgpc_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               busy_o,
  input logic               done_o,
  input logic [30:0]        linear_velocity_o,
  input logic signed [31:0] angular_velocity_o,
  input logic signed [15:0] heading_error_o,
  input logic signed [15:0] final_angle_error_o,
  input logic               stopped_o
);

  `PGPC_ASSERT_IMPLY(a_stop_lin, clk_i, rst_ni, done_o && stopped_o, linear_velocity_o == '0)
  `PGPC_ASSERT_IMPLY(a_stop_ang, clk_i, rst_ni, done_o && stopped_o, angular_velocity_o == '0)
  `PGPC_ASSERT_IMPLY(a_alpha_rng, clk_i, rst_ni, done_o, heading_error_o <= 16'sd25736 && heading_error_o >= -16'sd25736)
  `PGPC_ASSERT_IMPLY(a_beta_rng, clk_i, rst_ni, done_o, final_angle_error_o <= 16'sd25736 && final_angle_error_o >= -16'sd25736)
  `PGPC_ASSERT_NEXT(a_never_busy, clk_i, rst_ni, 1'b1, !busy_o)

endmodule

bind polar_goal_pose_controller_core pgpc_checker u_checker (
  .clk_i, .rst_ni, .busy_o, .done_o, .linear_velocity_o, .angular_velocity_o,
  .heading_error_o, .final_angle_error_o, .stopped_o
);
